### rtl/mrs_pkg.sv
// ----------------------------------------------------------------------------
// mrs_pkg
// Shared widths, mode and register codes, command and status types and the
// start-value helpers of the masked reduction statistics block.
// ----------------------------------------------------------------------------
`default_nettype none

package mrs_pkg;

    // Field widths
    localparam int SAMPLE_BITS      = 16;
    localparam int VALUE_BITS       = 64;
    localparam int USED_BITS        = 17;
    localparam int MODE_BITS        = 4;
    localparam int CFG_INDEX_BITS   = 1;
    localparam int CFG_DATA_BITS    = 4;
    localparam int MAX_SET_SIZE_DEF = 65536;

    // Mean results carry eight fraction bits (1.0 is 256)
    localparam int FRAC_BITS = 8;
    localparam int DIV_BITS  = VALUE_BITS + FRAC_BITS;
    localparam int DIV_STEPS = DIV_BITS;

    // Signed 64-bit limits
    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {1'b0, {(VALUE_BITS-1){1'b1}}};
    localparam logic [VALUE_BITS-1:0] VALUE_MIN = {1'b1, {(VALUE_BITS-1){1'b0}}};

    // Reduction modes
    localparam logic [MODE_BITS-1:0] MODE_SUM     = 4'd0;
    localparam logic [MODE_BITS-1:0] MODE_MEAN    = 4'd1;
    localparam logic [MODE_BITS-1:0] MODE_SUMABS  = 4'd2;
    localparam logic [MODE_BITS-1:0] MODE_MEANABS = 4'd3;
    localparam logic [MODE_BITS-1:0] MODE_SUMSQ   = 4'd4;
    localparam logic [MODE_BITS-1:0] MODE_MEANSQ  = 4'd5;
    localparam logic [MODE_BITS-1:0] MODE_PRODUCT = 4'd6;
    localparam logic [MODE_BITS-1:0] MODE_MAX     = 4'd7;
    localparam logic [MODE_BITS-1:0] MODE_MIN     = 4'd8;

    // Configuration register indexes
    localparam logic [CFG_INDEX_BITS-1:0] REG_REDUCE_MODE = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_MASK_ENABLE = 1'd1;

    // Controller to datapath commands
    typedef struct packed {
        logic capture;
        logic update;
        logic div_load;
        logic div_step;
        logic deliver;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic last_item;
        logic count_zero;
    } status_t;

    // Map the unused mode codes onto sum
    function automatic logic [MODE_BITS-1:0] eff_mode(input logic [MODE_BITS-1:0] m);
        return (m > MODE_MIN) ? MODE_SUM : m;
    endfunction

    function automatic logic is_mean(input logic [MODE_BITS-1:0] m);
        return (m == MODE_MEAN) || (m == MODE_MEANABS) || (m == MODE_MEANSQ);
    endfunction

    // Accumulator value at the start of a set
    function automatic logic [VALUE_BITS-1:0] start_value(input logic [MODE_BITS-1:0] m);
        logic [VALUE_BITS-1:0] r;
        unique case (m)
            MODE_PRODUCT: r = {{(VALUE_BITS-1){1'b0}}, 1'b1};
            MODE_MAX:     r = {{(VALUE_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
            MODE_MIN:     r = {{(VALUE_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
            default:      r = '0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

### rtl/masked_reduction_statistics.sv
// ----------------------------------------------------------------------------
// masked_reduction_statistics
// Each item is accepted, then applied to the accumulator in an update step.
// A set's result is loaded into the output register after the last item's
// update, once that register is free; mean modes over a non-empty set first
// pass the bit-serial divider (one load, then 72 quotient bits, one per cycle).
// Reset: sum mode, masking off, empty set, no result pending.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_reduction_statistics #(
    parameter int MAX_SET_SIZE = mrs_pkg::MAX_SET_SIZE_DEF
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    // configuration write port
    input  wire logic                                      cfg_we,
    input  wire logic [mrs_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  wire logic [mrs_pkg::CFG_DATA_BITS-1:0]         cfg_wdata,
    // sample channel
    input  wire logic                                      in_valid,
    output logic                                           in_stall,
    input  wire logic signed [mrs_pkg::SAMPLE_BITS-1:0]    sample,
    input  wire logic                                      included,
    input  wire logic                                      last_sample,
    // result channel
    output logic                                           out_valid,
    input  wire logic                                      out_stall,
    output logic signed [mrs_pkg::VALUE_BITS-1:0]          value,
    output logic [mrs_pkg::USED_BITS-1:0]                  used_count,
    output logic                                           overflowed
);

    logic [mrs_pkg::MODE_BITS-1:0] mode_reg, mode_next;
    logic                          mask_reg, mask_next;
    logic                          mode_wr;
    logic [mrs_pkg::MODE_BITS-1:0] mode_eff;
    logic [mrs_pkg::MODE_BITS-1:0] restart_mode;

    mrs_pkg::cmd_t    cmd;
    mrs_pkg::status_t status;

    // Configuration registers
    always_comb
    begin
        mode_wr   = cfg_we && (cfg_index == mrs_pkg::REG_REDUCE_MODE);
        mode_next = mode_wr ? cfg_wdata[mrs_pkg::MODE_BITS-1:0] : mode_reg;
        mask_next = (cfg_we && (cfg_index == mrs_pkg::REG_MASK_ENABLE)) ? cfg_wdata[0]
                                                                          : mask_reg;
        mode_eff     = mrs_pkg::eff_mode(mode_reg);
        restart_mode = mrs_pkg::eff_mode(mode_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg <= mrs_pkg::MODE_SUM;
            mask_reg <= 1'b0;
        end
        else
        begin
            mode_reg <= mode_next;
            mask_reg <= mask_next;
        end
    end

    mrs_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .mean_mode (mrs_pkg::is_mean(mode_eff)),
        .status    (status),
        .cmd       (cmd)
    );

    mrs_datapath #(
        .MAX_SET_SIZE (MAX_SET_SIZE)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample       (sample),
        .included     (included),
        .last_sample  (last_sample),
        .mode         (mode_eff),
        .restart_mode (restart_mode),
        .mask_enable  (mask_reg),
        .cfg_restart  (mode_wr),
        .cmd          (cmd),
        .status       (status),
        .value        (value),
        .used_count   (used_count),
        .overflowed   (overflowed)
    );

endmodule

`default_nettype wire

### rtl/mrs_datapath.sv
// ----------------------------------------------------------------------------
// mrs_datapath
// Accumulator, sample counter, saturation flag, product and square units,
// bit-serial mean divider and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrs_datapath #(
    parameter int MAX_SET_SIZE = mrs_pkg::MAX_SET_SIZE_DEF
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic signed [mrs_pkg::SAMPLE_BITS-1:0] sample,
    input  wire logic                                  included,
    input  wire logic                                  last_sample,
    input  wire logic [mrs_pkg::MODE_BITS-1:0]         mode,
    input  wire logic [mrs_pkg::MODE_BITS-1:0]         restart_mode,
    input  wire logic                                  mask_enable,
    input  wire logic                                  cfg_restart,
    input  wire mrs_pkg::cmd_t                         cmd,
    output mrs_pkg::status_t                           status,
    output logic signed [mrs_pkg::VALUE_BITS-1:0]      value,
    output logic [mrs_pkg::USED_BITS-1:0]              used_count,
    output logic                                       overflowed
);

    localparam int CNT_BITS  = $clog2(MAX_SET_SIZE + 1);
    localparam int SB        = mrs_pkg::SAMPLE_BITS;
    localparam int VB        = mrs_pkg::VALUE_BITS;
    localparam int HALF      = VB / 2;
    localparam int PP_BITS   = HALF + SB;
    localparam int PROD_BITS = VB + SB;
    localparam int DB        = mrs_pkg::DIV_BITS;
    localparam int FB        = mrs_pkg::FRAC_BITS;

    // State of the running set
    logic [VB-1:0]       acc_reg,   acc_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                sat_reg,   sat_next;

    // Captured item
    logic [VB-1:0]      term_reg;
    logic [PP_BITS-1:0] pp_lo_reg, pp_hi_reg;
    logic               neg_reg, use_reg, last_reg;

    // Divider
    logic [DB-1:0]       quo_reg;
    logic [CNT_BITS-1:0] rem_reg;
    logic                div_neg_reg;

    // Output register
    logic [VB-1:0]                value_reg;
    logic [mrs_pkg::USED_BITS-1:0] used_reg;
    logic                          ovf_reg;

    // Capture side
    logic [SB-1:0]     sample_u;
    logic [SB-1:0]     x_mag;
    logic [VB-1:0]     x_ext;
    logic [VB-1:0]     acc_mag;
    logic [2*SB-1:0]   x_sq;
    logic [VB-1:0]     term_in;
    logic              use_in, full;

    // Update side
    logic [VB-1:0]        sum;
    logic                 add_ovf;
    logic [PROD_BITS-1:0] prod, prod_lim;
    logic                 prod_sat;
    logic [VB-1:0]        acc_upd;
    logic                 upd_sat;

    // Divider and mean result
    logic [CNT_BITS:0]   rem_shift, rem_diff;
    logic                rem_ge;
    logic [DB-1:0]       mean_lim;
    logic                mean_sat, sel_mean;
    logic [VB-1:0]       mean_val;

    // Condition the incoming sample
    always_comb
    begin
        sample_u = sample;
        x_mag    = sample_u[SB-1] ? (~sample_u + 1'b1) : sample_u;
        x_ext    = {{(VB-SB){sample_u[SB-1]}}, sample_u};
        acc_mag  = acc_reg[VB-1] ? (~acc_reg + 1'b1) : acc_reg;
        x_sq     = x_mag * x_mag;
        use_in   = !(mask_enable && !included);
        full     = count_reg >= CNT_BITS'(MAX_SET_SIZE);
        unique case (mode)
            mrs_pkg::MODE_SUMABS, mrs_pkg::MODE_MEANABS: term_in = VB'(x_mag);
            mrs_pkg::MODE_SUMSQ,  mrs_pkg::MODE_MEANSQ:  term_in = VB'(x_sq);
            default:                                     term_in = x_ext;
        endcase
    end

    // Hold the captured item and its partial products
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            term_reg  <= term_in;
            pp_lo_reg <= acc_mag[HALF-1:0] * x_mag;
            pp_hi_reg <= acc_mag[VB-1:HALF] * x_mag;
            neg_reg   <= acc_reg[VB-1] ^ sample_u[SB-1];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            use_reg  <= 1'b0;
            last_reg <= 1'b0;
        end
        else if (cmd.capture)
        begin
            use_reg  <= use_in && !full;
            last_reg <= last_sample;
        end
    end

    // Combine the captured term with the accumulator
    always_comb
    begin
        sum      = acc_reg + term_reg;
        add_ovf  = (acc_reg[VB-1] == term_reg[VB-1]) && (sum[VB-1] != acc_reg[VB-1]);
        prod     = {pp_hi_reg, {HALF{1'b0}}} + PROD_BITS'(pp_lo_reg);
        prod_lim = PROD_BITS'(neg_reg ? mrs_pkg::VALUE_MIN : mrs_pkg::VALUE_MAX);
        prod_sat = prod > prod_lim;
        acc_upd  = acc_reg;
        upd_sat  = 1'b0;
        unique case (mode)
            mrs_pkg::MODE_PRODUCT:
            begin
                if (prod_sat)
                begin
                    acc_upd = neg_reg ? mrs_pkg::VALUE_MIN : mrs_pkg::VALUE_MAX;
                    upd_sat = 1'b1;
                end
                else
                begin
                    acc_upd = neg_reg ? (~prod[VB-1:0] + 1'b1) : prod[VB-1:0];
                end
            end
            mrs_pkg::MODE_MAX:
            begin
                if ($signed(term_reg) > $signed(acc_reg))
                    acc_upd = term_reg;
            end
            mrs_pkg::MODE_MIN:
            begin
                if ($signed(term_reg) < $signed(acc_reg))
                    acc_upd = term_reg;
            end
            default:
            begin
                if (add_ovf)
                begin
                    acc_upd = term_reg[VB-1] ? mrs_pkg::VALUE_MIN : mrs_pkg::VALUE_MAX;
                    upd_sat = 1'b1;
                end
                else
                begin
                    acc_upd = sum;
                end
            end
        endcase
    end

    // Next set state: restart, count on capture, apply on update
    always_comb
    begin
        acc_next   = acc_reg;
        count_next = count_reg;
        sat_next   = sat_reg;
        if (cmd.deliver || cfg_restart)
        begin
            acc_next   = mrs_pkg::start_value(restart_mode);
            count_next = '0;
            sat_next   = 1'b0;
        end
        else if (cmd.capture)
        begin
            if (use_in && !full)
                count_next = count_reg + 1'b1;
            if (use_in && full)
                sat_next = 1'b1;
        end
        else if (cmd.update && use_reg)
        begin
            acc_next = acc_upd;
            sat_next = sat_reg | upd_sat;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= mrs_pkg::start_value(mrs_pkg::MODE_SUM);
            count_reg <= '0;
            sat_reg   <= 1'b0;
        end
        else
        begin
            acc_reg   <= acc_next;
            count_reg <= count_next;
            sat_reg   <= sat_next;
        end
    end

    // One restoring division step per cycle: (|acc| * 256) / count
    always_comb
    begin
        rem_shift = {rem_reg, quo_reg[DB-1]};
        rem_diff  = rem_shift - {1'b0, count_reg};
        rem_ge    = rem_shift >= {1'b0, count_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.div_load)
        begin
            quo_reg     <= {acc_mag, {FB{1'b0}}};
            rem_reg     <= '0;
            div_neg_reg <= acc_reg[VB-1];
        end
        else if (cmd.div_step)
        begin
            quo_reg <= {quo_reg[DB-2:0], rem_ge};
            rem_reg <= rem_ge ? rem_diff[CNT_BITS-1:0] : rem_shift[CNT_BITS-1:0];
        end
    end

    // Saturate and sign the mean
    always_comb
    begin
        mean_lim = DB'(div_neg_reg ? mrs_pkg::VALUE_MIN : mrs_pkg::VALUE_MAX);
        mean_sat = quo_reg > mean_lim;
        if (mean_sat)
            mean_val = div_neg_reg ? mrs_pkg::VALUE_MIN : mrs_pkg::VALUE_MAX;
        else
            mean_val = div_neg_reg ? (~quo_reg[VB-1:0] + 1'b1) : quo_reg[VB-1:0];
        sel_mean = mrs_pkg::is_mean(mode) && (count_reg != '0);
    end

    // Load the result item
    always_ff @(posedge clk)
    begin
        if (cmd.deliver)
        begin
            value_reg <= sel_mean ? mean_val : acc_reg;
            used_reg  <= mrs_pkg::USED_BITS'(count_reg);
            ovf_reg   <= sat_reg | (sel_mean && mean_sat);
        end
    end

    assign value             = value_reg;
    assign used_count        = used_reg;
    assign overflowed        = ovf_reg;
    assign status.last_item  = last_reg;
    assign status.count_zero = (count_reg == '0);

    // The set never grows past its limit
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(MAX_SET_SIZE))
        else $error("sample count beyond set limit");

    // Partial remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.div_step |=> rem_reg < count_reg)
        else $error("divider remainder not below count");

    // Saturation clears only on a restart
    a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(sat_reg) |-> $past(cmd.deliver || cfg_restart))
        else $error("saturation flag lost within a set");

    // A saturated set reports overflow
    a_ovf_reported: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.deliver && sat_reg) |=> overflowed)
        else $error("saturated set delivered without overflow");

endmodule

`default_nettype wire

### rtl/mrs_ctrl.sv
// ----------------------------------------------------------------------------
// mrs_ctrl
// Controller: item handshake, update sequencing, divider step count and the
// valid bit of the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mrs_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    output logic                   out_valid,
    input  wire logic              out_stall,
    input  wire logic              mean_mode,
    input  wire mrs_pkg::status_t  status,
    output mrs_pkg::cmd_t          cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_UPDATE   = 3'd1;
    localparam logic [2:0] S_DIV_INIT = 3'd2;
    localparam logic [2:0] S_DIVIDE   = 3'd3;
    localparam logic [2:0] S_DELIVER  = 3'd4;

    localparam int STEP_BITS = $clog2(mrs_pkg::DIV_STEPS);
    localparam logic [STEP_BITS-1:0] STEP_LAST = STEP_BITS'(mrs_pkg::DIV_STEPS - 1);

    logic [2:0]           state_reg, state_next;
    logic [STEP_BITS-1:0] step_reg,  step_next;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_free;

    assign out_free = !out_valid_reg || !out_stall;

    // Sequence one item, then the set's result
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_UPDATE;
                end
            end
            S_UPDATE:
            begin
                cmd.update = 1'b1;
                if (!status.last_item)
                    state_next = S_IDLE;
                else if (mean_mode && !status.count_zero)
                    state_next = S_DIV_INIT;
                else
                    state_next = S_DELIVER;
            end
            S_DIV_INIT:
            begin
                cmd.div_load = 1'b1;
                step_next    = '0;
                state_next   = S_DIVIDE;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
                step_next    = step_reg + 1'b1;
                if (step_reg == STEP_LAST)
                    state_next = S_DELIVER;
            end
            S_DELIVER:
            begin
                if (out_free)
                begin
                    cmd.deliver = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Hold the result valid until taken, reload when a new one is ready
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.deliver)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

    // A result is never written over one still waiting
    a_deliver_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.deliver |-> (!out_valid_reg || !out_stall))
        else $error("result loaded over a pending one");

    // Output valid rises only from a delivery
    a_valid_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(cmd.deliver))
        else $error("output valid without a delivery");

    // The divider runs its full step count and then delivers
    a_div_length: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIVIDE && step_reg == STEP_LAST) |=> state_reg == S_DELIVER)
        else $error("divider did not finish on its last step");

endmodule

`default_nettype wire

### dv/masked_reduction_statistics_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// masked_reduction_statistics_tb
// Self-checking bench for the masked reduction block. A directed table covers
// reset defaults, every mode, empty sets, saturation and register side
// effects. Random sets in every mode code follow. Each result is checked
// against a local saturating predictor while both channels idle and stall at
// random.
// ----------------------------------------------------------------------------

module masked_reduction_statistics_tb;

    localparam logic [mrs_pkg::MODE_BITS-1:0] MODE_SPARE = 4'd15;
    localparam int unsigned SET_LIMIT   = mrs_pkg::MAX_SET_SIZE_DEF;
    localparam int          SETTLE      = 100;
    localparam int          RANDOM_ITEMS = 590;
    localparam int          HOLD_CYCLES = 400;

    typedef struct packed {
        logic [15:0] smp;
        logic        inc;
        logic        lst;
    } sample_t;

    typedef struct packed {
        logic [63:0] val;
        logic [16:0] cnt;
        logic        ovf;
    } stats_t;

    typedef struct packed {
        logic                          set_mode;
        logic [mrs_pkg::MODE_BITS-1:0] mode;
        logic                          set_mask;
        logic                          mask;
        logic [15:0]                   smp;
        logic                          inc;
        logic                          lst;
        logic                          pinned;
        logic [63:0]                   val;
        logic [16:0]                   cnt;
        logic                          ovf;
    } step_row_t;

    typedef enum logic [1:0] {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_TOGGLE
    } stall_style_t;

    // Opening sequence: a pinned row carries a result that is plain to see
    localparam step_row_t OPENING_ROWS [24] = '{
        // reset state: sum, masking off, so a cleared mask bit still counts
        '{1'b0, mrs_pkg::MODE_SUM, 1'b0, 1'b0, 16'h7FFF, 1'b0, 1'b1,
          1'b1, 64'd32767, 17'd1, 1'b0},
        '{1'b0, mrs_pkg::MODE_SUM, 1'b0, 1'b0, 16'd1000, 1'b1, 1'b0,
          1'b0, 64'd0, 17'd0, 1'b0},
        // a mode write drops the half-built set
        '{1'b1, mrs_pkg::MODE_SUM, 1'b0, 1'b0, 16'd5, 1'b1, 1'b1,
          1'b1, 64'd5, 17'd1, 1'b0},
        '{1'b0, mrs_pkg::MODE_SUM, 1'b0, 1'b0, 16'd10, 1'b1, 1'b0,
          1'b0, 64'd0, 17'd0, 1'b0},
        // a mask write keeps the half-built set; this item is skipped
        '{1'b0, mrs_pkg::MODE_SUM, 1'b1, 1'b1, 16'd20, 1'b0, 1'b0,
          1'b0, 64'd0, 17'd0, 1'b0},
        '{1'b0, mrs_pkg::MODE_SUM, 1'b0, 1'b1, 16'd30, 1'b1, 1'b1,
          1'b1, 64'd40, 17'd2, 1'b0},
        // mean of an empty set gives the sum
        '{1'b1, mrs_pkg::MODE_MEAN, 1'b0, 1'b1, 16'd100, 1'b0, 1'b1,
          1'b1, 64'd0, 17'd0, 1'b0},
        '{1'b0, mrs_pkg::MODE_MEAN, 1'b0, 1'b1, 16'd3, 1'b1, 1'b0,
          1'b0, 64'd0, 17'd0, 1'b0},
        '{1'b0, mrs_pkg::MODE_MEAN, 1'b0, 1'b1, 16'd4, 1'b1, 1'b1,
          1'b1, 64'd896, 17'd2, 1'b0},
        '{1'b1, mrs_pkg::MODE_MEANABS, 1'b1, 1'b0, 16'hFFFF, 1'b0, 1'b0,
          1'b0, 64'd0, 17'd0, 1'b0},
        '{1'b0, mrs_pkg::MODE_MEANABS, 1'b0, 1'b0, 16'hFFFE, 1'b0, 1'b1,
          1'b0, 64'd0, 17'd0, 1'b0},
        '{1'b1, mrs_pkg::MODE_SUMABS, 1'b0, 1'b0, 16'h8000, 1'b1, 1'b1,
          1'b0, 64'd0, 17'd0, 1'b0},
        '{1'b1, mrs_pkg::MODE_MEANSQ, 1'b0, 1'b0, 16'd3, 1'b1, 1'b0,
          1'b0, 64'd0, 17'd0, 1'b0},
        '{1'b0, mrs_pkg::MODE_MEANSQ, 1'b0, 1'b0, 16'hFFFE, 1'b1, 1'b1,
          1'b0, 64'd0, 17'd0, 1'b0},
        '{1'b1, mrs_pkg::MODE_SUMSQ, 1'b0, 1'b0, 16'h8000, 1'b1, 1'b1,
          1'b1, 64'd1073741824, 17'd1, 1'b0},
        // empty product gives its start value
        '{1'b1, mrs_pkg::MODE_PRODUCT, 1'b1, 1'b1, 16'd0, 1'b0, 1'b1,
          1'b1, 64'd1, 17'd0, 1'b0},
        '{1'b0, mrs_pkg::MODE_PRODUCT, 1'b0, 1'b1, 16'h8000, 1'b1, 1'b0,
          1'b0, 64'd0, 17'd0, 1'b0},
        '{1'b0, mrs_pkg::MODE_PRODUCT, 1'b0, 1'b1, 16'h8000, 1'b1, 1'b0,
          1'b0, 64'd0, 17'd0, 1'b0},
        '{1'b0, mrs_pkg::MODE_PRODUCT, 1'b0, 1'b1, 16'h8000, 1'b1, 1'b0,
          1'b0, 64'd0, 17'd0, 1'b0},
        '{1'b0, mrs_pkg::MODE_PRODUCT, 1'b0, 1'b1, 16'h8000, 1'b1, 1'b0,
          1'b0, 64'd0, 17'd0, 1'b0},
        // fifth factor overflows to the negative limit
        '{1'b0, mrs_pkg::MODE_PRODUCT, 1'b0, 1'b1, 16'h8000, 1'b1, 1'b1,
          1'b1, mrs_pkg::VALUE_MIN, 17'd5, 1'b1},
        // empty maximum and minimum give the extreme start values
        '{1'b1, mrs_pkg::MODE_MAX, 1'b0, 1'b1, 16'd0, 1'b0, 1'b1,
          1'b1, 64'hFFFF_FFFF_FFFF_8000, 17'd0, 1'b0},
        '{1'b1, mrs_pkg::MODE_MIN, 1'b0, 1'b1, 16'd0, 1'b0, 1'b1,
          1'b1, 64'd32767, 17'd0, 1'b0},
        // an unused mode code behaves as sum
        '{1'b1, MODE_SPARE, 1'b1, 1'b0, 16'hFFF7, 1'b0, 1'b1,
          1'b0, 64'd0, 17'd0, 1'b0}
    };

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  cfg_we      = 1'b0;
    logic [mrs_pkg::CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [mrs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                  in_valid    = 1'b0;
    logic                  in_stall;
    logic [15:0]           sample      = '0;
    logic                  included    = 1'b0;
    logic                  last_sample = 1'b0;
    logic                  out_valid;
    logic                  out_stall   = 1'b0;
    logic signed [63:0]    value;
    logic [mrs_pkg::USED_BITS-1:0] used_count;
    logic                  overflowed;

    // Predictor state
    logic [mrs_pkg::MODE_BITS-1:0] mode_sel;
    logic                  mask_on;
    logic signed [63:0]    run_acc;
    logic [31:0]           run_count;
    logic                  run_sat;

    stats_t expected_stats [$];
    int     errors       = 0;
    int     items_sent   = 0;
    int     burst_left   = 0;
    bit     back_to_back = 1'b0;
    bit     hold_req     = 1'b0;

    always #4 clk = ~clk;

    masked_reduction_statistics DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .sample      (sample),
        .included    (included),
        .last_sample (last_sample),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .value       (value),
        .used_count  (used_count),
        .overflowed  (overflowed)
    );

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    function automatic logic [mrs_pkg::MODE_BITS-1:0] active_mode();
        return (mode_sel > mrs_pkg::MODE_MIN) ? mrs_pkg::MODE_SUM : mode_sel;
    endfunction

    function automatic logic [63:0] magnitude(input logic signed [63:0] x);
        logic [63:0] u;
        u = x;
        return x[63] ? (64'd0 - u) : u;
    endfunction

    // Clamp a magnitude with a sign to the 64-bit range, flagging overflow
    function automatic logic [63:0] to_signed_sat(input logic [63:0] mag, input bit neg);
        if (neg) begin
            if (mag > mrs_pkg::VALUE_MIN) begin
                run_sat = 1'b1;
                mag = mrs_pkg::VALUE_MIN;
            end
            return 64'd0 - mag;
        end
        if (mag > mrs_pkg::VALUE_MAX) begin
            run_sat = 1'b1;
            mag = mrs_pkg::VALUE_MAX;
        end
        return mag;
    endfunction

    function automatic void restart_set();
        case (active_mode())
            mrs_pkg::MODE_PRODUCT: run_acc = 64'sd1;
            mrs_pkg::MODE_MAX:     run_acc = -(64'sd1 <<< (mrs_pkg::SAMPLE_BITS - 1));
            mrs_pkg::MODE_MIN:     run_acc = (64'sd1 <<< (mrs_pkg::SAMPLE_BITS - 1)) - 64'sd1;
            default:               run_acc = 64'sd0;
        endcase
        run_count = '0;
        run_sat = 1'b0;
    endfunction

    function automatic void add_saturating(input logic signed [63:0] b);
        logic signed [64:0] s;
        s = $signed({run_acc[63], run_acc}) + $signed({b[63], b});
        if (s[64] != s[63]) begin
            run_sat = 1'b1;
            run_acc = s[64] ? mrs_pkg::VALUE_MIN : mrs_pkg::VALUE_MAX;
        end
        else begin
            run_acc = s[63:0];
        end
    endfunction

    function automatic void mul_saturating(input logic signed [63:0] b);
        logic [63:0] ma;
        logic [63:0] mb;
        logic [63:0] lim;
        bit          neg;
        ma = magnitude(run_acc);
        mb = magnitude(b);
        neg = run_acc[63] ^ b[63];
        if (ma == 0 || mb == 0) begin
            run_acc = '0;
            return;
        end
        lim = neg ? mrs_pkg::VALUE_MIN : mrs_pkg::VALUE_MAX;
        if (ma > lim / mb) begin
            run_sat = 1'b1;
            run_acc = to_signed_sat(lim, neg);
        end
        else begin
            run_acc = to_signed_sat(ma * mb, neg);
        end
    endfunction

    // Mean with eight fraction bits, truncated toward zero
    function automatic logic [63:0] mean_fixed();
        logic [63:0] n;
        logic [63:0] mag;
        logic [63:0] q;
        logic [63:0] r;
        logic [63:0] m;
        bit          neg;
        n = 64'(run_count);
        if (n == 0)
            return run_acc;
        neg = run_acc[63];
        mag = magnitude(run_acc);
        q = mag / n;
        r = mag % n;
        if (q > (mrs_pkg::VALUE_MIN >> mrs_pkg::FRAC_BITS))
            return to_signed_sat(mrs_pkg::VALUE_MIN + 64'd1, neg);
        m = (q << mrs_pkg::FRAC_BITS) + ((r << mrs_pkg::FRAC_BITS) / n);
        return to_signed_sat(m, neg);
    endfunction

    function automatic void write_register(input logic [mrs_pkg::CFG_INDEX_BITS-1:0] idx,
                                           input logic [mrs_pkg::CFG_DATA_BITS-1:0] data);
        if (idx == mrs_pkg::REG_REDUCE_MODE) begin
            mode_sel = data;
            restart_set();
        end
        else if (idx == mrs_pkg::REG_MASK_ENABLE) begin
            mask_on = data[0];
        end
    endfunction

    // Fold one item into the running set; return 1 when it closes the set
    function automatic bit fold_sample(input sample_t it, output stats_t res);
        logic signed [63:0]            x;
        logic [63:0]                   mx;
        logic [mrs_pkg::MODE_BITS-1:0] md;
        bit                            take;
        x = $signed(it.smp);
        mx = magnitude(x);
        md = active_mode();
        take = !(mask_on && !it.inc);
        res = '0;
        if (take && run_count >= SET_LIMIT) begin
            take = 1'b0;
            run_sat = 1'b1;
        end
        if (take) begin
            run_count = run_count + 1;
            case (md)
                mrs_pkg::MODE_SUMABS, mrs_pkg::MODE_MEANABS: add_saturating(mx);
                mrs_pkg::MODE_SUMSQ, mrs_pkg::MODE_MEANSQ:   add_saturating(mx * mx);
                mrs_pkg::MODE_PRODUCT:                       mul_saturating(x);
                mrs_pkg::MODE_MAX:                           if (x > run_acc) run_acc = x;
                mrs_pkg::MODE_MIN:                           if (x < run_acc) run_acc = x;
                default:                                     add_saturating(x);
            endcase
        end
        if (!it.lst)
            return 1'b0;
        if (md == mrs_pkg::MODE_MEAN || md == mrs_pkg::MODE_MEANABS ||
            md == mrs_pkg::MODE_MEANSQ)
            res.val = mean_fixed();
        else
            res.val = run_acc;
        res.cnt = run_count[16:0];
        res.ovf = run_sat;
        restart_set();
        return 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------

    // Offer one item in bursts with random gaps; return once it is taken
    task automatic offer_sample(input sample_t it, input bit pinned, input stats_t pinned_val);
        stats_t res;
        int     gap;
        if (!back_to_back && burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            if (gap != 0) begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        if (burst_left > 0)
            burst_left = burst_left - 1;
        if (fold_sample(it, res))
            expected_stats.push_back(pinned ? pinned_val : res);
        items_sent = items_sent + 1;
        in_valid    <= 1'b1;
        sample      <= it.smp;
        included    <= it.inc;
        last_sample <= it.lst;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    // Drop valid, wait for every result, then let the divider settle
    task automatic wait_idle();
        in_valid <= 1'b0;
        while (expected_stats.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_cfg(input logic [mrs_pkg::CFG_INDEX_BITS-1:0] idx,
                             input logic [mrs_pkg::CFG_DATA_BITS-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        write_register(idx, data);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [15:0] pick_sample();
        int v;
        case ($urandom_range(0, 9))
            0:       return 16'h8000;
            1:       return 16'h7FFF;
            2:       return 16'h0000;
            3:       return $urandom_range(0, 1) ? 16'h0001 : 16'hFFFF;
            4, 5, 6:
            begin
                v = int'($urandom_range(0, 16)) - 8;
                return v[15:0];
            end
            default: return 16'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall pattern and checking
    // ------------------------------------------------------------------

    always @(posedge clk) begin : result_side
        stats_t              want;
        stall_style_t        style;
        int                  style_left;
        int                  hold_left;
        // check the item taken at this edge
        if (rst_n && out_valid && !out_stall) begin
            if (expected_stats.size() == 0) begin
                errors = errors + 1;
                $display("%0t: unexpected result: value %0d used_count %0d overflowed %0b",
                         $time, value, used_count, overflowed);
            end
            else begin
                want = expected_stats.pop_front();
                if (want.val !== value) begin
                    errors = errors + 1;
                    $display("%0t: value expected %0d got %0d",
                             $time, $signed(want.val), value);
                end
                if (want.cnt !== used_count) begin
                    errors = errors + 1;
                    $display("%0t: used_count expected %0d got %0d",
                             $time, want.cnt, used_count);
                end
                if (want.ovf !== overflowed) begin
                    errors = errors + 1;
                    $display("%0t: overflowed expected %0b got %0b",
                             $time, want.ovf, overflowed);
                end
            end
        end
        // pick the stall for the next cycle
        if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else begin
            if (style_left <= 0) begin
                style = stall_style_t'($urandom_range(0, 3));
                style_left = $urandom_range(8, 80);
            end
            style_left = style_left - 1;
            case (style)
                STALL_NONE:   out_stall <= 1'b0;
                STALL_LIGHT:  out_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY:  out_stall <= ($urandom_range(0, 3) != 0);
                default:      out_stall <= ~out_stall;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin : stimulus
        sample_t                       it;
        stats_t                        pv;
        step_row_t                     row;
        logic [mrs_pkg::MODE_BITS-1:0] md;
        int                            phase;
        int                            n_sets;
        int                            size;
        int                            start_count;
        mode_sel = mrs_pkg::MODE_SUM;
        mask_on = 1'b0;
        restart_set();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Walk the opening table
        for (int i = 0; i < 24; i++) begin
            row = OPENING_ROWS[i];
            if (row.set_mode || row.set_mask)
                wait_idle();
            if (row.set_mode)
                write_cfg(mrs_pkg::REG_REDUCE_MODE, row.mode);
            if (row.set_mask)
                write_cfg(mrs_pkg::REG_MASK_ENABLE, {3'($urandom_range(0, 7)), row.mask});
            it = '{row.smp, row.inc, row.lst};
            pv = '{row.val, row.cnt, row.ovf};
            offer_sample(it, row.pinned, pv);
        end

        // Hold the result side off while single-item sets pile up
        wait_idle();
        write_cfg(mrs_pkg::REG_REDUCE_MODE, mrs_pkg::MODE_SUM);
        hold_req = 1'b1;
        back_to_back = 1'b1;
        for (int i = 0; i < 40; i++) begin
            it = '{pick_sample(), 1'b1, 1'b1};
            offer_sample(it, 1'b0, '0);
        end
        back_to_back = 1'b0;

        // Random sets, one phase per setting; every mode code comes first
        start_count = items_sent;
        phase = 0;
        while (items_sent - start_count < RANDOM_ITEMS) begin
            wait_idle();
            md = (phase < 16) ? mrs_pkg::MODE_BITS'(phase)
                              : mrs_pkg::MODE_BITS'($urandom_range(0, 15));
            write_cfg(mrs_pkg::REG_REDUCE_MODE, md);
            write_cfg(mrs_pkg::REG_MASK_ENABLE,
                      mrs_pkg::CFG_DATA_BITS'($urandom_range(0, 15)));
            n_sets = $urandom_range(2, 8);
            for (int s = 0; s < n_sets; s++) begin
                size = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
                                                   : $urandom_range(1, 8);
                for (int k = 0; k < size; k++) begin
                    it = '{pick_sample(), ($urandom_range(0, 3) != 0), (k == size - 1)};
                    offer_sample(it, 1'b0, '0);
                end
            end
            // leave a partial set behind now and then; the next mode write drops it
            if ($urandom_range(0, 3) == 0) begin
                size = $urandom_range(1, 3);
                for (int k = 0; k < size; k++) begin
                    it = '{pick_sample(), 1'b1, 1'b0};
                    offer_sample(it, 1'b0, '0);
                end
            end
            phase = phase + 1;
        end

        wait_idle();
        if (errors == 0)
            $display("masked_reduction_statistics: match");
        else
            $display("masked_reduction_statistics: mismatch");
        $finish;
    end

    // Give up well beyond the slowest correct run
    initial begin : watchdog
        #10_000_000;
        $display("masked_reduction_statistics: mismatch");
        $finish;
    end

endmodule
